// ===== hdl/named_shared_variable_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Named shared variable table assertion macros
// Concurrent check wrappers clocked on aclk for the variable table unit.
// ----------------------------------------------------------------------------
`ifndef NAMED_SHARED_VARIABLE_TABLE_UNIT_MACROS_SVH
`define NAMED_SHARED_VARIABLE_TABLE_UNIT_MACROS_SVH

// Check that is switched off while reset is held.
`define NSVT_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that stays active through reset; the property guards itself.
`define NSVT_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/nsvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Named shared variable table package
// Item types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package nsvt_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int KEY_BITS       = 64;
    localparam int VALUE_BITS     = 32;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_GET  = 2'd1,
        OP_SET  = 2'd2,
        OP_ADD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        op_t                   opcode;
        logic [KEY_BITS-1:0]   name_key;
        logic [VALUE_BITS-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic                  created;
        status_t               status;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/named_shared_variable_table_unit.sv =====
// Lookup: a name found in entry k ends the key memory scan there; a missing name is
// scanned against all ENTRIES entries, one entry a cycle.
// Throughput: one item at a time; a new item is taken the cycle after its result is
// registered.
// Reset: aresetn clears all live bits at once; key and value memories are not cleared.
// ----------------------------------------------------------------------------
// Named shared variable table unit
// Keyed table of 32-bit variables with init, get, set and add operations.
// Keys and values sit in memories with one read port and one write port, scanned in order.
// ----------------------------------------------------------------------------
`default_nettype none
`include "named_shared_variable_table_unit_macros.svh"

module named_shared_variable_table_unit
    import nsvt_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_data
);

    localparam int KEY_W = 8 * NAME_BYTES;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [ENTRIES-1:0]    live_reg, live_next;
    logic                  m_valid_reg, m_valid_next;
    res_t                  m_data_reg, m_data_next;
    res_t                  res_reg, res_next;
    op_t                   op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] operand_reg;

    logic [KEY_W-1:0]      key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [KEY_W-1:0]      key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;

    logic                  accept;
    logic [IDX_W-1:0]      rd_addr;
    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VALUE_BITS-1:0] upd_value;
    logic                  match_hit;
    logic                  scan_end;

    assign s_ready = (state_reg == IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign rd_addr = cnt_reg[IDX_W-1:0];

    assign match_hit = cmp_vld_reg && live_reg[cmp_idx_reg] && (key_rd_reg == key_reg);
    assign scan_end  = !cmp_vld_reg && (cnt_reg == CNT_END);

    always_comb begin
        case (op_reg)
            OP_SET:  upd_value = operand_reg;
            OP_ADD:  upd_value = val_rd_reg + operand_reg;
            default: upd_value = val_rd_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        live_next     = live_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        res_next      = res_reg;
        key_we        = 1'b0;
        val_we        = 1'b0;
        wr_addr       = cmp_idx_reg;
        val_wdata     = upd_value;

        case (state_reg)
            IDLE: begin
                if (accept) begin
                    state_next    = SCAN;
                    cnt_next      = '0;
                    free_vld_next = 1'b0;
                end
            end
            SCAN: begin
                if (cnt_reg != CNT_END) begin
                    cnt_next     = cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                end
                if (match_hit) begin
                    state_next   = RESP;
                    cmp_vld_next = 1'b0;
                    val_we       = (op_reg == OP_SET) || (op_reg == OP_ADD);
                    res_next     = '{read_value: upd_value, created: 1'b0, status: ST_OK};
                end else if (cmp_vld_reg && !live_reg[cmp_idx_reg]) begin
                    free_vld_next = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end else if (scan_end) begin
                    state_next = RESP;
                    if (op_reg == OP_GET) begin
                        res_next = '{read_value: '0, created: 1'b0, status: ST_NOT_FOUND};
                    end else if (!free_vld_reg) begin
                        res_next = '{read_value: '0, created: 1'b0, status: ST_FULL};
                    end else begin
                        key_we    = 1'b1;
                        val_we    = 1'b1;
                        wr_addr   = free_idx_reg;
                        val_wdata = operand_reg;
                        live_next[free_idx_reg] = 1'b1;
                        res_next  = '{read_value: operand_reg, created: 1'b1, status: ST_OK};
                    end
                end
            end
            RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            live_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            free_vld_reg <= free_vld_next;
            live_reg     <= live_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        if (accept) begin
            op_reg      <= s_data.opcode;
            key_reg     <= s_data.name_key[KEY_W-1:0];
            operand_reg <= s_data.operand_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_reg;
        end
        if (val_we) begin
            val_mem[wr_addr] <= val_wdata;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    `NSVT_CHECK(a_alloc_free_slot, key_we |-> !live_reg[wr_addr],
        "Key written into a live entry")
    `NSVT_CHECK(a_created_ok, m_valid && m_data.created |-> m_data.status == ST_OK,
        "Created item without ok status")
    `NSVT_CHECK_ALWAYS(a_live_grows,
        aresetn && $past(aresetn) |-> $countones(live_reg) >= $past($countones(live_reg)),
        "Live entry count dropped")

endmodule
`default_nettype wire
